// File: sv/evad_pkg.sv
package evad_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FRAMES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_LEN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TALK_LEN     = 3'd4;

  localparam logic [14:0] THRESHOLD_RST    = 15'd500;
  localparam logic [3:0]  START_FRAMES_RST = 4'd2;
  localparam logic [7:0]  HANG_LEN_RST     = 8'd10;
  localparam logic [7:0]  QUIET_LIMIT_RST  = 8'd40;
  localparam logic [15:0] MIN_TALK_LEN_RST = 16'd10;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_WAITING = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPEECH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SILENCE = 2'd2;

  localparam int SQ_W = 31;

  typedef struct packed {
    logic [14:0] energy_threshold;
    logic [3:0]  start_frames;
    logic [7:0]  hang_len;
    logic [7:0]  quiet_limit;
    logic [15:0] min_talk_len;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic mul;
    logic dec;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/evad_track.sv
module evad_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        voiced,
  input  evad_pkg::cfg_t              cfg,
  output logic [evad_pkg::MODE_W-1:0] mode_nxt,
  output logic                        eos
);

  logic [evad_pkg::MODE_W-1:0] mode_r;
  logic [15:0] speech_r, speech_nxt, speech_bump;
  logic [7:0]  silence_r, silence_nxt, silence_inc;
  logic [7:0]  hang_r, hang_nxt;

  assign speech_bump = (speech_r == 16'hFFFF) ? speech_r : speech_r + 16'd1;
  assign silence_inc = (silence_r == 8'hFF) ? silence_r : silence_r + 8'd1;

  always_comb begin
    mode_nxt    = mode_r;
    speech_nxt  = speech_r;
    silence_nxt = silence_r;
    hang_nxt    = hang_r;
    eos         = 1'b0;
    unique case (mode_r)
      evad_pkg::MODE_WAITING: begin
        if (voiced) begin
          speech_nxt = speech_bump;
          if (speech_bump >= {12'd0, cfg.start_frames}) begin
            mode_nxt = evad_pkg::MODE_SPEECH;
            hang_nxt = cfg.hang_len;
          end
        end else begin
          speech_nxt = 16'd0;
        end
      end
      evad_pkg::MODE_SPEECH: begin
        speech_nxt = speech_bump;
        if (voiced) begin
          hang_nxt = cfg.hang_len;
        end else if (hang_r <= 8'd1) begin
          hang_nxt    = 8'd0;
          mode_nxt    = evad_pkg::MODE_SILENCE;
          silence_nxt = 8'd1;
        end else begin
          hang_nxt = hang_r - 8'd1;
        end
      end
      default: begin
        if (voiced) begin
          mode_nxt    = evad_pkg::MODE_SPEECH;
          silence_nxt = 8'd0;
          hang_nxt    = cfg.hang_len;
        end else if (silence_inc >= cfg.quiet_limit) begin
          eos         = (speech_r >= cfg.min_talk_len);
          mode_nxt    = evad_pkg::MODE_WAITING;
          speech_nxt  = 16'd0;
          silence_nxt = 8'd0;
          hang_nxt    = 8'd0;
        end else begin
          silence_nxt = silence_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= evad_pkg::MODE_WAITING;
      speech_r  <= 16'd0;
      silence_r <= 8'd0;
      hang_r    <= 8'd0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      speech_r  <= speech_nxt;
      silence_r <= silence_nxt;
      hang_r    <= hang_nxt;
    end
  end

endmodule

// File: sv/evad_datapath.sv
module evad_datapath #(
  parameter int FRAME_MAX_SAMPLES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [15:0]          in_sample,
  input  logic                        in_frame_last,
  input  evad_pkg::cfg_t              cfg,
  input  evad_pkg::dp_cmd_t           cmd,
  output evad_pkg::dp_status_t        status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [evad_pkg::MODE_W-1:0] out_detector_mode,
  output logic                        out_utterance_end,
  output logic                        out_frame_voiced
);

  localparam int CNT_W  = $clog2(FRAME_MAX_SAMPLES + 1);
  localparam int SUM_W  = evad_pkg::SQ_W - 1 + CNT_W;
  localparam int PROD_W = evad_pkg::SQ_W + CNT_W;

  logic signed [31:0]        sq_full;
  logic [15:0]               thr_p1;
  logic [31:0]               thr_full;
  logic [evad_pkg::SQ_W-1:0] sq_r, thr_sq_r;
  logic                      last_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          cnt_r, cnt_inc;
  logic [PROD_W-1:0]         prod_r;
  logic                      voiced;
  logic [evad_pkg::MODE_W-1:0] mode_nxt;
  logic                      eos;
  logic                      out_valid_r;

  assign sq_full  = in_sample * in_sample;
  assign thr_p1   = {1'b0, cfg.energy_threshold} + 16'd1;
  assign thr_full = thr_p1 * thr_p1;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign voiced   = PROD_W'(sum_r) >= prod_r;

  assign status.frame_end = last_r || (cnt_inc == CNT_W'(FRAME_MAX_SAMPLES));
  assign status.out_free  = !out_valid_r || out_ready;

  evad_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (cmd.dec),
    .voiced   (voiced),
    .cfg      (cfg),
    .mode_nxt (mode_nxt),
    .eos      (eos)
  );

  always_ff @(posedge clk) begin
    thr_sq_r <= thr_full[evad_pkg::SQ_W-1:0];
    if (cmd.load) begin
      sq_r   <= sq_full[evad_pkg::SQ_W-1:0];
      last_r <= in_frame_last;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(thr_sq_r) * PROD_W'(cnt_r);
    end
    if (cmd.dec) begin
      out_detector_mode <= mode_nxt;
      out_utterance_end <= eos;
      out_frame_voiced  <= voiced;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        sum_r <= sum_r + SUM_W'(sq_r);
        cnt_r <= cnt_inc;
      end else if (cmd.dec) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.dec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/evad_ctrl.sv
module evad_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  evad_pkg::dp_status_t status,
  output evad_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.frame_end ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (status.out_free) begin
          cmd.dec   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/energy_voice_activity_detector.sv
// A sample that does not end a frame is accepted and then accumulated.
// A frame-ending sample steps through accept, accumulate, threshold multiply
// and decision. Input is accepted only in the idle state, between these steps.
// A result not yet taken holds the next frame's decision, and input then waits until it is taken.
// Synchronous active-low reset restores register defaults and clears the control
// state, sample counter, energy sum and output valid; no clearing pass is needed.
module energy_voice_activity_detector #(
  parameter int FRAME_MAX_SAMPLES = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_sample,
  input  logic                            in_frame_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [evad_pkg::MODE_W-1:0]     out_detector_mode,
  output logic                            out_utterance_end,
  output logic                            out_frame_voiced,
  input  logic                            cfg_wr_en,
  input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  evad_pkg::cfg_t       cfg_r;
  evad_pkg::dp_cmd_t    cmd;
  evad_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold <= evad_pkg::THRESHOLD_RST;
      cfg_r.start_frames     <= evad_pkg::START_FRAMES_RST;
      cfg_r.hang_len         <= evad_pkg::HANG_LEN_RST;
      cfg_r.quiet_limit      <= evad_pkg::QUIET_LIMIT_RST;
      cfg_r.min_talk_len     <= evad_pkg::MIN_TALK_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        evad_pkg::REG_ENERGY_THRESHOLD: cfg_r.energy_threshold <= cfg_wdata[14:0];
        evad_pkg::REG_START_FRAMES:     cfg_r.start_frames     <= cfg_wdata[3:0];
        evad_pkg::REG_HANG_LEN:         cfg_r.hang_len         <= cfg_wdata[7:0];
        evad_pkg::REG_QUIET_LIMIT:      cfg_r.quiet_limit      <= cfg_wdata[7:0];
        evad_pkg::REG_MIN_TALK_LEN:     cfg_r.min_talk_len     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  evad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  evad_datapath #(
    .FRAME_MAX_SAMPLES (FRAME_MAX_SAMPLES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sample         (in_sample),
    .in_frame_last     (in_frame_last),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_detector_mode (out_detector_mode),
    .out_utterance_end (out_utterance_end),
    .out_frame_voiced  (out_frame_voiced)
  );

endmodule

// File: sv/evad_checker.sv
module evad_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [evad_pkg::MODE_W-1:0] out_detector_mode,
  input logic                        out_utterance_end,
  input logic                        out_frame_voiced
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_detector_mode)
      && $stable(out_utterance_end) && $stable(out_frame_voiced))
    else $error("Stalled result changed or was dropped.");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_detector_mode == evad_pkg::MODE_WAITING)
      || (out_detector_mode == evad_pkg::MODE_SPEECH)
      || (out_detector_mode == evad_pkg::MODE_SILENCE))
    else $error("Result carries an unused mode code.");

  a_eos_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_utterance_end |->
      out_detector_mode == evad_pkg::MODE_WAITING && !out_frame_voiced)
    else $error("End of speech reported outside a quiet return to waiting.");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted on two consecutive cycles.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (.*);
